@@ sv/isou8_pkg.sv @@
// ----------------------------------------------------------------------------
// isou8_pkg
// Shared types, constants and the accent lookup for the ISO 6937 subset to
// UTF-8 transcoder.
// ----------------------------------------------------------------------------
`default_nettype none

package isou8_pkg;

    // Pending diacritic prefix
    typedef enum logic [1:0] {
        PFX_NONE  = 2'd0,
        PFX_ACUTE = 2'd1,
        PFX_CARON = 2'd2,
        PFX_RING  = 2'd3
    } pfx_t;

    localparam logic [7:0] BYTE_ACUTE = 8'hC2;
    localparam logic [7:0] BYTE_CARON = 8'hCF;
    localparam logic [7:0] BYTE_RING  = 8'hCA;
    localparam logic [7:0] BYTE_AMP   = 8'h26;
    localparam logic [7:0] ASCII_MAX  = 8'h7F;

    localparam int unsigned RUN_DEPTH = 5;
    localparam int unsigned RUN_CNT_W = $clog2(RUN_DEPTH + 1);

    // "&amp;" with element 0 sent first
    localparam logic [RUN_DEPTH-1:0][7:0] AMP_ESCAPE =
        {8'h3B, 8'h70, 8'h6D, 8'h61, 8'h26};

    localparam logic [RUN_CNT_W-1:0] CNT_ONE  = RUN_CNT_W'(1);
    localparam logic [RUN_CNT_W-1:0] CNT_PAIR = RUN_CNT_W'(2);
    localparam logic [RUN_CNT_W-1:0] CNT_AMP  = RUN_CNT_W'(RUN_DEPTH);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } out_item_t;

    // Output bytes caused by one input transaction
    typedef struct packed {
        logic [RUN_DEPTH-1:0][7:0] bytes;
        logic [RUN_CNT_W-1:0]      cnt;
    } run_t;

    // Code point of the accented letter, zero when the pair is unknown
    function automatic logic [8:0] accent_lookup(input pfx_t pfx, input logic [7:0] base);
        logic [8:0] cp;
        cp = 9'h000;
        unique case (pfx)
            PFX_ACUTE:
                unique case (base)
                    "A": cp = 9'h0C1;  "a": cp = 9'h0E1;
                    "E": cp = 9'h0C9;  "e": cp = 9'h0E9;
                    "I": cp = 9'h0CD;  "i": cp = 9'h0ED;
                    "O": cp = 9'h0D3;  "o": cp = 9'h0F3;
                    "U": cp = 9'h0DA;  "u": cp = 9'h0FA;
                    "Y": cp = 9'h0DD;  "y": cp = 9'h0FD;
                    default: cp = 9'h000;
                endcase
            PFX_CARON:
                unique case (base)
                    "C": cp = 9'h10C;  "c": cp = 9'h10D;
                    "D": cp = 9'h10E;  "d": cp = 9'h10F;
                    "E": cp = 9'h11A;  "e": cp = 9'h11B;
                    "N": cp = 9'h147;  "n": cp = 9'h148;
                    "R": cp = 9'h158;  "r": cp = 9'h159;
                    "S": cp = 9'h160;  "s": cp = 9'h161;
                    "T": cp = 9'h164;  "t": cp = 9'h165;
                    "Z": cp = 9'h17D;  "z": cp = 9'h17E;
                    default: cp = 9'h000;
                endcase
            PFX_RING:
                unique case (base)
                    "U": cp = 9'h16E;  "u": cp = 9'h16F;
                    default: cp = 9'h000;
                endcase
            default: cp = 9'h000;
        endcase
        return cp;
    endfunction

endpackage

`default_nettype wire

@@ sv/iso6937_subset_to_utf8.sv @@
// ----------------------------------------------------------------------------
// iso6937_subset_to_utf8: an input byte passes the input register and then the run buffer before output.
// Throughput: one output byte per cycle while utf8_ready is high. The run buffer sets the rate:
// a decoded byte with output waits in the input register until the run buffer is free, so "&"
// (five bytes) and an accented letter (two bytes) stall input while they are sent; other bytes do not.
// Reset: rst_n async active low clears valids and pending prefix; payload regs not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module iso6937_subset_to_utf8
    import isou8_pkg::*;
(
    input  var logic      clk,
    input  var logic      rst_n,
    input  var logic      coded_valid,
    output logic          coded_ready,
    input  var in_item_t  coded,
    output logic          utf8_valid,
    input  var logic      utf8_ready,
    output out_item_t     utf8
);

    // Input register: one accepted transaction waiting for decode
    logic     s1_valid_reg;
    logic     s1_valid_next;
    in_item_t s1_item_reg;

    // Pending diacritic prefix, advanced in input order
    pfx_t     pending_reg;
    pfx_t     pending_next;

    run_t     dec_run;
    logic     run_free;
    logic     s1_adv;
    logic     run_load;

    isou8_decode u_decode (
        .item         (s1_item_reg),
        .pending      (pending_reg),
        .run          (dec_run),
        .pending_next (pending_next)
    );

    // Advance the decoded item: runs with no bytes retire at once, others
    // need the run buffer free (empty or sending its last byte now).
    assign s1_adv      = s1_valid_reg && ((dec_run.cnt == '0) || run_free);
    assign run_load    = s1_adv && (dec_run.cnt != '0);
    assign coded_ready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (coded_valid && coded_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            pending_reg  <= PFX_NONE;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (s1_adv)
            begin
                pending_reg <= pending_next;
            end
        end
    end

    // Capture payload on every input transaction
    always_ff @(posedge clk)
    begin
        if (coded_valid && coded_ready)
        begin
            s1_item_reg <= coded;
        end
    end

    isou8_run_buf u_run_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (run_load),
        .run        (dec_run),
        .free       (run_free),
        .utf8_valid (utf8_valid),
        .utf8_ready (utf8_ready),
        .utf8       (utf8)
    );

`ifndef ASSERT_OFF
    a_end_clears_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_item_reg.string_end) |=> (pending_reg == PFX_NONE))
        else $error("prefix left pending after string end");

    a_prefix_consumed: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && pending_reg != PFX_NONE) |=> (pending_reg == PFX_NONE))
        else $error("prefix not consumed by base letter");

    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_item_reg)
                                       && $stable(pending_reg)))
        else $error("stalled input item or prefix changed");
`endif

endmodule

`default_nettype wire

@@ sv/isou8_decode.sv @@
// ----------------------------------------------------------------------------
// isou8_decode
// Maps one coded byte and the pending prefix to its run of UTF-8 bytes and
// the next pending prefix.
// ----------------------------------------------------------------------------
`default_nettype none

module isou8_decode
    import isou8_pkg::*;
(
    input  var in_item_t item,
    input  var pfx_t     pending,
    output run_t         run,
    output pfx_t         pending_next
);

    logic [8:0] cp;

    assign cp = accent_lookup(pending, item.in_byte);

    always_comb
    begin
        run          = '0;
        pending_next = pending;
        if (pending != PFX_NONE)
        begin
            // base letter: always consumed, dropped when unknown
            pending_next = PFX_NONE;
            if (cp != 9'h000)
            begin
                run.bytes[0] = {5'b11000, cp[8:6]};
                run.bytes[1] = {2'b10, cp[5:0]};
                run.cnt      = CNT_PAIR;
            end
        end
        else
        begin
            unique case (item.in_byte)
                BYTE_ACUTE: pending_next = PFX_ACUTE;
                BYTE_CARON: pending_next = PFX_CARON;
                BYTE_RING:  pending_next = PFX_RING;
                BYTE_AMP:
                begin
                    run.bytes = AMP_ESCAPE;
                    run.cnt   = CNT_AMP;
                end
                default:
                begin
                    if (item.in_byte <= ASCII_MAX)
                    begin
                        run.bytes[0] = item.in_byte;
                        run.cnt      = CNT_ONE;
                    end
                end
            endcase
        end
        if (item.string_end)
        begin
            pending_next = PFX_NONE;
        end
    end

endmodule

`default_nettype wire

@@ sv/isou8_run_buf.sv @@
// ----------------------------------------------------------------------------
// isou8_run_buf
// Holds one run of output bytes and sends it one byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module isou8_run_buf
    import isou8_pkg::*;
(
    input  var logic      clk,
    input  var logic      rst_n,
    input  var logic      load,
    input  var run_t      run,
    output logic          free,
    output logic          utf8_valid,
    input  var logic      utf8_ready,
    output out_item_t     utf8
);

    localparam int unsigned IDX_W = $clog2(RUN_DEPTH);

    logic                      valid_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic [RUN_DEPTH-1:0][7:0] bytes_reg;
    logic [RUN_CNT_W-1:0]      cnt_reg;
    logic                      last;
    logic                      fire;

    assign last = (RUN_CNT_W'(idx_reg) == RUN_CNT_W'(cnt_reg - CNT_ONE));
    assign fire = valid_reg && utf8_ready;
    assign free = !valid_reg || (fire && last);

    assign utf8_valid    = valid_reg;
    assign utf8.out_byte = bytes_reg[idx_reg];
    assign utf8.run_last = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end
        else if (fire && last)
        begin
            valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            idx_reg <= IDX_W'(idx_reg + 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bytes_reg <= run.bytes;
            cnt_reg   <= run.cnt;
        end
    end

`ifndef ASSERT_OFF
    a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (cnt_reg != '0))
        else $error("run buffer holds an empty run");

    a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (RUN_CNT_W'(idx_reg) < cnt_reg))
        else $error("run index past end of run");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !last) |=> (valid_reg && idx_reg == IDX_W'($past(idx_reg) + 1'b1)))
        else $error("run cut short before its last byte");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free)
        else $error("run loaded over a run still in flight");
`endif

endmodule

`default_nettype wire
